@@ sv/bpse_pkg.sv @@
// Shared types and constants for the BER printable string extractor.
package bpse_pkg;

    localparam logic [7:0] TAG_OCTET_STRING = 8'h04;
    localparam logic [7:0] TAG_SEQUENCE     = 8'h30;
    localparam logic [7:0] TAG_CONTEXT_0    = 8'hA0;
    localparam logic [7:0] TAG_CONTEXT_2    = 8'hA2;
    localparam logic [7:0] CHAR_TAB         = 8'h09;
    localparam logic [7:0] CHAR_LF          = 8'h0A;
    localparam logic [7:0] CHAR_CR          = 8'h0D;
    localparam logic [7:0] PRINT_LOW        = 8'h20;
    localparam logic [7:0] PRINT_HIGH       = 8'h7E;
    localparam logic [9:0] COUNT_MAX        = 10'd1023;

    localparam logic KIND_TEXT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LEN,
        PH_LENEXT,
        PH_SKIP,
        PH_STRING
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } request_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
        logic [9:0] string_number;
        logic       string_end;
        logic       string_ok;
        logic [9:0] strings_found;
    } result_t;

    // One queued job: an optional text beat and an optional summary beat.
    typedef struct packed {
        logic       has_text;
        logic [7:0] text_byte;
        logic [9:0] string_number;
        logic       string_end;
        logic       string_ok;
        logic       has_summary;
        logic [9:0] strings_found;
    } job_t;

endpackage

@@ sv/bpse_front.sv @@
// Front end: BER header parser that queues a job for string bytes and final bytes.
module bpse_front #(
    parameter int MAX_LENGTH_BYTES = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bpse_pkg::request_t request,
    output logic              job_write,
    output bpse_pkg::job_t    job
);
    import bpse_pkg::*;

    localparam int ACC_W  = 8 * MAX_LENGTH_BYTES;
    localparam int LEFT_W = $clog2(MAX_LENGTH_BYTES + 1);

    phase_t             phase_reg, phase_next;
    logic [7:0]         held_tag_reg, held_tag_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic [ACC_W-1:0]   rem_reg, rem_next;
    logic               community_reg, community_next;
    logic               all_print_reg, all_print_next;
    logic [9:0]         count_reg, count_next;

    logic [7:0]         b;
    logic               eop;
    logic [ACC_W+7:0]   acc_cat;
    logic [ACC_W-1:0]   rem_dec;
    logic [LEFT_W-1:0]  left_dec;
    logic               byte_ok;
    logic               str_last;
    logic               str_ok;
    logic               hd_en;
    logic [ACC_W-1:0]   hd_len;
    logic               hd_generic;

    assign b        = request.data_byte;
    assign eop      = request.end_of_packet;
    assign acc_cat  = {acc_reg, b};
    assign rem_dec  = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
    assign byte_ok  = (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR)
                      || ((b >= PRINT_LOW) && (b <= PRINT_HIGH));
    assign str_last = (rem_dec == '0);
    assign str_ok   = str_last && all_print_reg && byte_ok;

    // Next state.
    always_comb
    begin
        phase_next     = phase_reg;
        held_tag_next  = held_tag_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;
        rem_next       = rem_reg;
        community_next = community_reg;
        all_print_next = all_print_reg;
        count_next     = count_reg;
        hd_en          = 1'b0;
        hd_len         = '0;
        hd_generic     = 1'b0;

        unique case (phase_reg)
            PH_TAG:
            begin
                held_tag_next = b;
                phase_next    = PH_LEN;
            end
            PH_LEN:
            begin
                if (b[7])
                begin
                    // Bad long form: reread as a new tag.
                    if ((b[6:0] == 7'd0) || (b[6:0] > 7'(MAX_LENGTH_BYTES)))
                    begin
                        held_tag_next = b;
                    end
                    else
                    begin
                        acc_next   = '0;
                        left_next  = LEFT_W'(b[6:0]);
                        phase_next = PH_LENEXT;
                    end
                end
                else
                begin
                    hd_en  = 1'b1;
                    hd_len = {{(ACC_W-7){1'b0}}, b[6:0]};
                end
            end
            PH_LENEXT:
            begin
                acc_next  = acc_cat[ACC_W-1:0];
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    hd_en  = 1'b1;
                    hd_len = acc_cat[ACC_W-1:0];
                end
            end
            PH_SKIP:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_STRING:
            begin
                rem_next = rem_dec;
                if (!byte_ok)
                begin
                    all_print_next = 1'b0;
                end
                if (str_last)
                begin
                    if (str_ok && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    all_print_next = 1'b1;
                    phase_next     = PH_TAG;
                end
            end
            default:
            begin
                phase_next = PH_TAG;
            end
        endcase

        // Header complete: enter, skip or extract.
        if (hd_en)
        begin
            priority if (held_tag_reg == TAG_OCTET_STRING)
            begin
                if (!community_reg)
                begin
                    community_next = 1'b1;
                    hd_generic     = 1'b1;
                end
                else if (hd_len != '0)
                begin
                    all_print_next = 1'b1;
                    rem_next       = hd_len;
                    phase_next     = PH_STRING;
                end
                else
                begin
                    phase_next = PH_TAG;
                end
            end
            else if ((held_tag_reg == TAG_SEQUENCE) || (held_tag_reg == TAG_CONTEXT_0)
                     || (held_tag_reg == TAG_CONTEXT_2))
            begin
                phase_next = PH_TAG;
            end
            else
            begin
                hd_generic = 1'b1;
            end
            if (hd_generic)
            begin
                if (hd_len == '0)
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    rem_next   = hd_len;
                    phase_next = PH_SKIP;
                end
            end
        end

        // Drop all parse state at the end of the packet.
        if (eop)
        begin
            phase_next     = PH_TAG;
            held_tag_next  = '0;
            acc_next       = '0;
            left_next      = '0;
            rem_next       = '0;
            community_next = 1'b0;
            all_print_next = 1'b1;
            count_next     = '0;
        end
    end

    // Job outputs.
    always_comb
    begin
        job               = '0;
        job.has_text      = (phase_reg == PH_STRING);
        job.text_byte     = b;
        job.string_number = count_reg;
        job.string_end    = str_last;
        job.string_ok     = str_ok;
        job.has_summary   = eop;
        job.strings_found = count_next;
        if (phase_reg != PH_STRING)
        begin
            job.text_byte     = '0;
            job.string_number = '0;
            job.string_end    = 1'b0;
            job.string_ok     = 1'b0;
        end
        if (eop)
        begin
            // The count is post-update here; take it before the clear.
            job.strings_found = (str_ok && (count_reg != COUNT_MAX)
                                 && (phase_reg == PH_STRING))
                                ? count_reg + 1'b1 : count_reg;
        end
        else
        begin
            job.strings_found = '0;
        end
        job_write = accept && (job.has_text || job.has_summary);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TAG;
            held_tag_reg  <= '0;
            acc_reg       <= '0;
            left_reg      <= '0;
            rem_reg       <= '0;
            community_reg <= 1'b0;
            all_print_reg <= 1'b1;
            count_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            held_tag_reg  <= held_tag_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            rem_reg       <= rem_next;
            community_reg <= community_next;
            all_print_reg <= all_print_next;
            count_reg     <= count_next;
        end
    end

endmodule

@@ sv/bpse_fifo.sv @@
// Small job queue between the parser and the result stage.
module bpse_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           write,
    input  bpse_pkg::job_t write_data,
    output logic           full,
    input  logic           read,
    output bpse_pkg::job_t read_data,
    output logic           empty
);
    import bpse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_write;
    logic             do_read;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_write  = write && !full;
    assign do_read   = read && !empty;
    assign read_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_write)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_read)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_write && !do_read)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_read && !do_write)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slots[wr_ptr_reg] <= write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/bpse_back.sv @@
// Back end: result register that expands each job into one or two result beats.
module bpse_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bpse_pkg::job_t   job,
    input  logic             job_empty,
    output logic             job_read,
    output logic             empty,
    input  logic             pop,
    output bpse_pkg::result_t result
);
    import bpse_pkg::*;

    job_t cur_reg;
    logic cur_valid_reg, cur_valid_next;
    logic text_done_reg, text_done_next;
    logic show_text;
    logic finish;

    assign show_text = cur_reg.has_text && !text_done_reg;
    // Job leaves once its last beat is taken.
    assign finish    = pop && cur_valid_reg && !(show_text && cur_reg.has_summary);
    assign job_read  = !job_empty && (!cur_valid_reg || finish);
    assign empty     = !cur_valid_reg;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        text_done_next = text_done_reg;
        if (job_read)
        begin
            cur_valid_next = 1'b1;
            text_done_next = 1'b0;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (pop && cur_valid_reg)
        begin
            text_done_next = 1'b1;
        end
    end

    always_comb
    begin
        result = '0;
        if (show_text)
        begin
            result.kind          = KIND_TEXT;
            result.text_byte     = cur_reg.text_byte;
            result.string_number = cur_reg.string_number;
            result.string_end    = cur_reg.string_end;
            result.string_ok     = cur_reg.string_ok;
        end
        else
        begin
            result.kind          = KIND_SUMMARY;
            result.strings_found = cur_reg.strings_found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_read)
        begin
            cur_reg <= job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            text_done_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            text_done_reg <= text_done_next;
        end
    end

endmodule

@@ sv/ber_printable_string_extractor.sv @@
// Top level of the BER printable string extractor.
// Usage:
//   Input queue side: drive request (data_byte, end_of_packet) with push;
//   a beat is taken at a clock edge where push is high and full is low.
//   One datagram byte per beat, end_of_packet high on its final byte.
//   Result queue side: while empty is low, result holds the oldest beat;
//   it is taken at an edge where pop is high. kind 0 is a string content
//   byte, kind 1 the end-of-packet summary with strings_found.
// Timing:
//   A result beat's job is written into the job queue at the edge that
//   takes its input beat, then moved into the result register that drives
//   the result port. The parser takes one byte every cycle while full is
//   low; a final byte in a string yields a text beat and a summary beat.
// Stall:
//   The job queue (FIFO_DEPTH entries) and the result register absorb a
//   stalled consumer; once the queue fills, full rises and holds input.
// Reset:
//   rst_n clears the parser to await a tag and empties both queues; no
//   result is pending afterwards.
module ber_printable_string_extractor #(
    parameter int MAX_LENGTH_BYTES = 2,
    parameter int FIFO_DEPTH       = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bpse_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output bpse_pkg::result_t result
);
    import bpse_pkg::*;

    logic accept;
    logic job_write;
    job_t job_in;
    job_t job_out;
    logic job_read;
    logic job_empty;

    // Advance the parser on every accepted beat.
    assign accept = push && !full;

    bpse_front #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .job_write (job_write),
        .job       (job_in)
    );

    bpse_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .write      (job_write),
        .write_data (job_in),
        .full       (full),
        .read       (job_read),
        .read_data  (job_out),
        .empty      (job_empty)
    );

    bpse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_read  (job_read),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
